### rtl/rqr_pkg.sv
// Shared types and constants for the request queue with removal.
package rqr_pkg;

	typedef enum logic [2:0] {
		ACT_ENQ   = 3'd0,
		ACT_DEQ   = 3'd1,
		ACT_RMPOS = 3'd2,
		ACT_RMKEY = 3'd3,
		ACT_PEEK  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SEARCH,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic [15:0] desc;
		logic [31:0] sec;
		logic [19:0] usec;
	} entry_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] desc;
		logic [31:0] sec;
		logic [19:0] usec;
	} result_t;

	localparam logic [6:0] CAP_RESET = 7'd64;

endpackage

### rtl/rqr_mem.sv
// Entry storage: one write port and one registered read port.
module rqr_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rqr_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output rqr_pkg::entry_t rdata
);

	rqr_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/rqr_seq.sv
// Sequencer: walks the storage one entry per cycle to search, read and compact.
module rqr_seq #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       action,
	input  logic [15:0]      descriptor,
	input  logic [31:0]      arrival_sec,
	input  logic [19:0]      arrival_usec,
	input  logic [5:0]       position,
	input  logic [6:0]       capacity,
	input  rqr_pkg::entry_t  rd_data,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output rqr_pkg::entry_t  mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	output logic             busy,
	output logic             done,
	output rqr_pkg::result_t result,
	output logic [CW-1:0]    count
);

	localparam int NW = CW + 1;
	localparam int PW = (NW > 7) ? NW : 7;

	rqr_pkg::state_t  state_q, state_d;
	rqr_pkg::action_t act_q, act_d;
	rqr_pkg::result_t res_q, res_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [CW-1:0]    count_q, count_d;
	logic [15:0]      key_q, key_d;
	logic             done_q, done_d;
	logic [NW-1:0]    cnt_n, nxt1, nxt2;
	logic             full, pos_ok, take;

	assign cnt_n  = NW'(count_q);
	assign nxt1   = NW'(idx_q) + NW'(1);
	assign nxt2   = NW'(idx_q) + NW'(2);
	assign full   = (PW'(count_q) >= PW'(capacity)) || (count_q >= CW'(DEPTH));
	assign pos_ok = PW'(position) < PW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rqr_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q <= act_d;
		res_q <= res_d;
		idx_q <= idx_d;
		key_q <= key_d;
	end

	always_comb begin
		state_d   = state_q;
		act_d     = act_q;
		res_d     = res_q;
		idx_d     = idx_q;
		count_d   = count_q;
		key_d     = key_q;
		done_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_data;
		mem_raddr = idx_q;
		take      = 1'b0;
		case (state_q)
			rqr_pkg::ST_IDLE: begin
				if (start) begin
					act_d = rqr_pkg::action_t'(action);
					key_d = descriptor;
					res_d = '0;
					idx_d = '0;
					case (rqr_pkg::action_t'(action))
						rqr_pkg::ACT_ENQ: begin
							if (!full) begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = '{desc: descriptor, sec: arrival_sec,
									usec: arrival_usec};
								count_d   = count_q + CW'(1);
								res_d.ok  = 1'b1;
							end
							done_d = 1'b1;
						end
						rqr_pkg::ACT_DEQ, rqr_pkg::ACT_PEEK: begin
							if (count_q != '0) begin
								mem_raddr = '0;
								state_d   = rqr_pkg::ST_LOAD;
							end else begin
								done_d = 1'b1;
							end
						end
						rqr_pkg::ACT_RMPOS: begin
							if (pos_ok) begin
								mem_raddr = AW'(position);
								idx_d     = AW'(position);
								state_d   = rqr_pkg::ST_LOAD;
							end else begin
								done_d = 1'b1;
							end
						end
						rqr_pkg::ACT_RMKEY: begin
							if (count_q != '0) begin
								mem_raddr = '0;
								state_d   = rqr_pkg::ST_SEARCH;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			rqr_pkg::ST_LOAD: begin
				take = 1'b1;
			end
			rqr_pkg::ST_SEARCH: begin
				if (rd_data.desc == key_q) begin
					take = 1'b1;
				end else if (nxt1 < cnt_n) begin
					idx_d     = AW'(nxt1);
					mem_raddr = AW'(nxt1);
				end else begin
					state_d = rqr_pkg::ST_IDLE;
					done_d  = 1'b1;
				end
			end
			rqr_pkg::ST_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = rd_data;
				idx_d     = AW'(nxt1);
				if (nxt2 < cnt_n) begin
					mem_raddr = AW'(nxt2);
				end else begin
					count_d = count_q - CW'(1);
					state_d = rqr_pkg::ST_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = rqr_pkg::ST_IDLE;
			end
		endcase
		if (take) begin
			res_d.ok   = 1'b1;
			res_d.sec  = rd_data.sec;
			res_d.usec = rd_data.usec;
			if (act_q != rqr_pkg::ACT_PEEK) begin
				res_d.desc = rd_data.desc;
				if (nxt1 < cnt_n) begin
					mem_raddr = AW'(nxt1);
					state_d   = rqr_pkg::ST_SHIFT;
				end else begin
					count_d = count_q - CW'(1);
					state_d = rqr_pkg::ST_IDLE;
					done_d  = 1'b1;
				end
			end else begin
				state_d = rqr_pkg::ST_IDLE;
				done_d  = 1'b1;
			end
		end
	end

	assign busy   = state_q != rqr_pkg::ST_IDLE;
	assign done   = done_q;
	assign result = res_q;
	assign count  = count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rqr_pkg::ST_IDLE) |-> (count_q != '0))
		else $error("walking storage with no entries held");
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rqr_pkg::ST_SHIFT) |-> (nxt1 < cnt_n))
		else $error("compaction beyond last entry");
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !res_q.ok) |-> (res_q.desc == '0 && res_q.sec == '0 && res_q.usec == '0))
		else $error("failed beat carries data");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> done_q)
		else $error("count changed without a result");
`endif

endmodule

### rtl/request_queue_with_removal.sv
// Top level of the bounded request queue with removal by position and descriptor.
//
//  channel   handshake              fields
//  command   start, busy            action, descriptor, arrival_sec, arrival_usec, position
//  result    done (one cycle)       ok, removed_descriptor, time_sec_out, time_usec_out,
//                                   entry_count, is_empty
//  config    cfg_we                 cfg_wdata (capacity_limit)
//
// A command is taken when start is high and busy is low; done rises in the cycle after it ends.
// Enqueue and commands refused at once (empty, out of range, unknown) are handled in idle;
// peek and removals load an entry, a key search first scans from index 0 to the first match:
// the single storage read port walks one entry per cycle to search and then to close the gap.
// Reset clears the count and sets the limit to 64; storage needs no clearing.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module request_queue_with_removal #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [15:0] descriptor,
	input  logic [31:0] arrival_sec,
	input  logic [19:0] arrival_usec,
	input  logic [5:0]  position,
	output logic        done,
	output logic        ok,
	output logic [15:0] removed_descriptor,
	output logic [31:0] time_sec_out,
	output logic [19:0] time_usec_out,
	output logic [6:0]  entry_count,
	output logic        is_empty,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [6:0]       capacity_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	rqr_pkg::entry_t  mem_wdata, rd_data;
	rqr_pkg::result_t result;
	logic [CW-1:0]    count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= rqr_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	rqr_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	rqr_seq #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.descriptor  (descriptor),
		.arrival_sec (arrival_sec),
		.arrival_usec(arrival_usec),
		.position    (position),
		.capacity    (capacity_q),
		.rd_data     (rd_data),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.count       (count)
	);

	assign ok                 = result.ok;
	assign removed_descriptor = result.desc;
	assign time_sec_out       = result.sec;
	assign time_usec_out      = result.usec;
	assign entry_count        = 7'(count);
	assign is_empty           = count == '0;

endmodule

### dv/testbench.sv
// Self-checking testbench for the bounded request queue with removal.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        ok;
		logic [15:0] desc;
		logic [31:0] sec;
		logic [19:0] usec;
		logic [6:0]  count;
		logic        empty;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  action;
	logic [15:0] descriptor;
	logic [31:0] arrival_sec;
	logic [19:0] arrival_usec;
	logic [5:0]  position;
	logic        done;
	logic        ok;
	logic [15:0] removed_descriptor;
	logic [31:0] time_sec_out;
	logic [19:0] time_usec_out;
	logic [6:0]  entry_count;
	logic        is_empty;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;

	logic [15:0] slot_desc [DEPTH];
	logic [31:0] slot_sec [DEPTH];
	logic [19:0] slot_usec [DEPTH];
	int          held;
	int          capacity_reg;

	outcome_t    pending_outcomes [$];
	outcome_t    oldest;
	int          errors;
	int          cycles;
	int          idle_pct;

	request_queue_with_removal #(
		.DEPTH(DEPTH)
	) u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.action             (action),
		.descriptor         (descriptor),
		.arrival_sec        (arrival_sec),
		.arrival_usec       (arrival_usec),
		.position           (position),
		.done               (done),
		.ok                 (ok),
		.removed_descriptor (removed_descriptor),
		.time_sec_out       (time_sec_out),
		.time_usec_out      (time_usec_out),
		.entry_count        (entry_count),
		.is_empty           (is_empty),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic outcome_t apply_request(logic [2:0] act, logic [15:0] desc,
			logic [31:0] sec, logic [19:0] usec, logic [5:0] pos);
		outcome_t r;
		int cap;
		int hit;
		int i;
		r = '0;
		cap = (capacity_reg < DEPTH) ? capacity_reg : DEPTH;
		hit = -1;
		case (act)
			rqr_pkg::ACT_ENQ: begin
				if (held < cap) begin
					slot_desc[held] = desc;
					slot_sec[held] = sec;
					slot_usec[held] = usec;
					held++;
					r.ok = 1'b1;
				end
			end
			rqr_pkg::ACT_DEQ: begin
				if (held > 0)
					hit = 0;
			end
			rqr_pkg::ACT_RMPOS: begin
				if (int'(pos) < held)
					hit = int'(pos);
			end
			rqr_pkg::ACT_RMKEY: begin
				for (i = held - 1; i >= 0; i--)
					if (slot_desc[i] == desc)
						hit = i;
			end
			rqr_pkg::ACT_PEEK: begin
				if (held > 0) begin
					r.ok = 1'b1;
					r.sec = slot_sec[0];
					r.usec = slot_usec[0];
				end
			end
			default: ;
		endcase
		if (hit >= 0) begin
			r.ok = 1'b1;
			r.desc = slot_desc[hit];
			r.sec = slot_sec[hit];
			r.usec = slot_usec[hit];
			for (i = hit; i + 1 < held; i++) begin
				slot_desc[i] = slot_desc[i + 1];
				slot_sec[i] = slot_sec[i + 1];
				slot_usec[i] = slot_usec[i + 1];
			end
			held--;
		end
		r.count = 7'(held);
		r.empty = (held == 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t unexpected result beat: actual ok %0b count %0d",
					$time, ok, entry_count);
				errors++;
			end else begin
				oldest = pending_outcomes.pop_front();
				check_field("ok", 32'(oldest.ok), 32'(ok));
				check_field("removed_descriptor", 32'(oldest.desc), 32'(removed_descriptor));
				check_field("time_sec_out", oldest.sec, time_sec_out);
				check_field("time_usec_out", 32'(oldest.usec), 32'(time_usec_out));
				check_field("entry_count", 32'(oldest.count), 32'(entry_count));
				check_field("is_empty", 32'(oldest.empty), 32'(is_empty));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, pending_outcomes.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(logic [2:0] act, logic [15:0] desc, logic [31:0] sec,
			logic [19:0] usec, logic [5:0] pos);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		descriptor <= desc;
		arrival_sec <= sec;
		arrival_usec <= usec;
		position <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_outcomes.push_back(apply_request(act, desc, sec, usec, pos));
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_outcomes.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limit(int value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = value;
	endtask

	task automatic send_random_request(int enq_pct);
		logic [2:0]  act;
		logic [15:0] desc;
		logic [31:0] sec;
		logic [19:0] usec;
		logic [5:0]  pos;
		int          pick;
		pick = $urandom_range(99);
		if ($urandom_range(99) < enq_pct)
			act = rqr_pkg::ACT_ENQ;
		else if (pick < 25)
			act = rqr_pkg::ACT_DEQ;
		else if (pick < 55)
			act = rqr_pkg::ACT_RMPOS;
		else if (pick < 85)
			act = rqr_pkg::ACT_RMKEY;
		else if (pick < 95)
			act = rqr_pkg::ACT_PEEK;
		else
			act = rqr_pkg::ACT_PEEK + 3'($urandom_range(1, 3));
		pick = $urandom_range(99);
		if (pick < 45)
			desc = 16'($urandom_range(0, 15));
		else if (pick < 75 && held > 0)
			desc = slot_desc[$urandom_range(0, held - 1)];
		else
			desc = 16'($urandom);
		pick = $urandom_range(9);
		sec = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
		if ($urandom_range(99) < 85)
			usec = 20'($urandom_range(0, 999999));
		else
			usec = 20'($urandom_range(0, 20'hFFFFF));
		if ($urandom_range(99) < 65)
			pos = 6'($urandom_range(0, (held < DEPTH) ? held : DEPTH - 1));
		else
			pos = 6'($urandom_range(0, 63));
		send_request(act, desc, sec, usec, pos);
	endtask

	task automatic test_empty_and_order();
		int k;
		send_request(rqr_pkg::ACT_PEEK, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_DEQ, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_RMPOS, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_RMKEY, 16'h0, 32'h0, 20'h0, 6'd0);
		for (k = 1; k <= 3; k++)
			send_request(rqr_pkg::ACT_PEEK + 3'(k), 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF,
				6'd63);
		send_request(rqr_pkg::ACT_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF, 6'd63);
		send_request(rqr_pkg::ACT_ENQ, 16'h0000, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_ENQ, 16'h1234, 32'h1, 20'd999999, 6'd0);
		send_request(rqr_pkg::ACT_ENQ, 16'h1234, 32'h2, 20'h5, 6'd0);
		send_request(rqr_pkg::ACT_ENQ, 16'hAAAA, 32'h5555_5555, 20'hAAAAA, 6'd0);
		send_request(rqr_pkg::ACT_ENQ, 16'h5555, 32'hAAAA_AAAA, 20'h55555, 6'd0);
		send_request(rqr_pkg::ACT_PEEK, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_RMKEY, 16'h1234, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_RMPOS, 16'h0, 32'h0, 20'h0, 6'd63);
		send_request(rqr_pkg::ACT_RMPOS, 16'h0, 32'h0, 20'h0, 6'd1);
		send_request(rqr_pkg::ACT_RMPOS, 16'h0, 32'h0, 20'h0, 6'd3);
		send_request(rqr_pkg::ACT_RMKEY, 16'hBEEF, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_PEEK + 3'd3, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_DEQ, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_RMPOS, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_DEQ, 16'h0, 32'h0, 20'h0, 6'd0);
		drain();
	endtask

	task automatic test_capacity_extremes();
		write_limit(1);
		send_request(rqr_pkg::ACT_ENQ, 16'h0042, 32'h10, 20'h20, 6'd0);
		send_request(rqr_pkg::ACT_ENQ, 16'h0043, 32'h11, 20'h21, 6'd0);
		write_limit(0);
		send_request(rqr_pkg::ACT_ENQ, 16'h0044, 32'h12, 20'h22, 6'd0);
		send_request(rqr_pkg::ACT_DEQ, 16'h0, 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_ENQ, 16'h0045, 32'h13, 20'h23, 6'd0);
		write_limit(64);
	endtask

	task automatic test_fill_and_drain();
		int n;
		idle_pct = 0;
		write_limit(64);
		while (held < DEPTH)
			send_random_request(100);
		send_random_request(100);
		send_request(rqr_pkg::ACT_RMPOS, 16'h0, 32'h0, 20'h0, 6'd63);
		send_random_request(100);
		send_random_request(100);
		send_request(rqr_pkg::ACT_RMKEY, slot_desc[held - 1], 32'h0, 20'h0, 6'd0);
		send_request(rqr_pkg::ACT_PEEK, 16'h0, 32'h0, 20'h0, 6'd0);
		for (n = 0; n < 300 && held > 0; n++)
			send_random_request(10);
		idle_pct = 20;
		drain();
	endtask

	task automatic test_lowered_limit();
		int n;
		write_limit(64);
		while (held < 30)
			send_random_request(100);
		write_limit(10);
		for (n = 0; n < 40; n++)
			send_random_request(50);
	endtask

	task automatic test_random_mix();
		int round;
		int n;
		int enq_pct;
		for (round = 0; round < 6; round++) begin
			if (round == 0)
				write_limit(64);
			else if (round == 1)
				write_limit(1);
			else
				write_limit($urandom_range(1, 64));
			enq_pct = $urandom_range(35, 70);
			for (n = 0; n < 70; n++)
				send_random_request(enq_pct);
		end
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		idle_pct = 20;
		held = 0;
		capacity_reg = 64;
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= rqr_pkg::ACT_ENQ;
		descriptor <= '0;
		arrival_sec <= '0;
		arrival_usec <= '0;
		position <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= rqr_pkg::CAP_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_order();
		test_capacity_extremes();
		test_fill_and_drain();
		test_lowered_limit();
		test_random_mix();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
rtl/rqr_pkg.sv
rtl/rqr_mem.sv
rtl/rqr_seq.sv
rtl/request_queue_with_removal.sv
dv/testbench.sv
